[rtl/core/stepper_trapezoid_profile_assert.svh]
// Assertion macros used by the checker file.
`ifndef STEPPER_TRAPEZOID_PROFILE_ASSERT_SVH
`define STEPPER_TRAPEZOID_PROFILE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define STP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define STP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/stp_pkg.sv]
`default_nettype none

package stp_pkg;

   // Input operation codes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_DELAY = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_DELAY = 1'b1;

   // Register reset values
   localparam int MIN_DELAY_RESET = 5;
   localparam int MAX_DELAY_RESET = 20;

   // Shared arithmetic unit modes
   localparam logic [1:0] ALU_MUL = 2'd0;
   localparam logic [1:0] ALU_DIV = 2'd1;
   localparam logic [1:0] ALU_FIN = 2'd2;
   localparam logic [1:0] ALU_OFF = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic       down;
   } alu_ctrl_type;

   function automatic logic [7:0] coil_of(input logic [1:0] ph);
      logic [7:0] c;
      unique case (ph)
         2'd0: c = 8'b0011_0000;
         2'd1: c = 8'b0000_0110;
         2'd2: c = 8'b0010_1000;
         2'd3: c = 8'b0000_0101;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

[rtl/core/stp_if.sv]
`default_nettype none

interface stp_req_if #(
   parameter int COUNT_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic signed [COUNT_BITS-1:0] move_count;
   logic [1:0]                   start_phase;

   modport source(output valid, op, move_count, start_phase, input ready);
   modport sink(input valid, op, move_count, start_phase, output ready);
endinterface

interface stp_rsp_if #(
   parameter int DELAY_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic [7:0]            coil_pattern;
   logic [3:0]            phase_flag;
   logic [1:0]            phase;
   logic [DELAY_BITS-1:0] step_delay;
   logic                  move_done;

   modport source(output valid, coil_pattern, phase_flag, phase, step_delay, move_done,
                  input ready);
   modport sink(input valid, coil_pattern, phase_flag, phase, step_delay, move_done,
                output ready);
endinterface

`default_nettype wire

[rtl/core/stepper_trapezoid_profile.sv]
// Channel   Dir  Payload                                           Handshake
// req_ch    in   op, move_count, start_phase                       valid/ready
// rsp_ch    out  coil_pattern, phase_flag, phase, step_delay,      valid/ready
//                move_done
// csr_*     in   csr_index, csr_wdata                              csr_we, no wait
//
// A start, an idle tick or a countdown tick is handled in S_IDLE alone. A done word
// or a step at the flat top speed also passes through S_PUT. A step on a ramp makes
// DELAY_BITS shift-add passes and DELAY_BITS restoring divide passes
// through the one shared adder in stp_alu, then a final add and the hand-off.
// Reset is synchronous; it clears control state and loads the delay registers.
// A stalled rsp_ch holds its word; a new word waits in a pending register and
// blocks req_ch until the output register frees up.
`default_nettype none

module stepper_trapezoid_profile #(
   parameter int COUNT_BITS = 16,
   parameter int DELAY_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   stp_req_if.sink                             req_ch,
   stp_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [stp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [DELAY_BITS-1:0]               csr_wdata
);
   import stp_pkg::*;

   localparam int MAG_BITS = COUNT_BITS - 1;
   localparam int PW       = MAG_BITS + DELAY_BITS;
   localparam int CNT_BITS = $clog2(DELAY_BITS);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_PUT  = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [DELAY_BITS-1:0]  min_ff, min_in;
   logic [DELAY_BITS-1:0]  max_ff, max_in;
   logic                   busy_ff, busy_in;
   logic                   backward_ff, backward_in;
   logic [MAG_BITS-1:0]    total_ff, total_in;
   logic [MAG_BITS-1:0]    index_ff, index_in;
   logic [MAG_BITS-1:0]    ramp_ff, ramp_in;
   logic [MAG_BITS-1:0]    desc_ff, desc_in;
   logic [1:0]             phase_ff, phase_in;
   logic [DELAY_BITS-1:0]  wait_ff, wait_in;
   logic [MAG_BITS-1:0]    mcand_ff, mcand_in;
   logic [PW-1:0]          acc_ff, acc_in;
   logic                   down_ff, down_in;

   // pending word, waiting for the output register
   logic [7:0]             pend_coil_ff, pend_coil_in;
   logic [3:0]             pend_flag_ff, pend_flag_in;
   logic [1:0]             pend_phase_ff, pend_phase_in;
   logic [DELAY_BITS-1:0]  pend_delay_ff, pend_delay_in;
   logic                   pend_done_ff, pend_done_in;

   // output register
   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_coil_ff, out_coil_in;
   logic [3:0]             out_flag_ff, out_flag_in;
   logic [1:0]             out_phase_ff, out_phase_in;
   logic [DELAY_BITS-1:0]  out_delay_ff, out_delay_in;
   logic                   out_done_ff, out_done_in;

   logic                   accept;
   logic [DELAY_BITS-1:0]  lo;
   logic [DELAY_BITS-1:0]  hi;
   logic [DELAY_BITS-1:0]  span;
   logic [COUNT_BITS-1:0]  count_u;
   logic [COUNT_BITS-1:0]  count_neg;
   logic [COUNT_BITS-1:0]  mag_full;
   logic [MAG_BITS-1:0]    mag;
   logic [1:0]             flag_sel;
   logic [1:0]             next_phase;
   alu_ctrl_type           alu_ctrl;
   logic [PW-1:0]          alu_acc;
   logic [DELAY_BITS-1:0]  alu_delay;

   // Effective profile limits; max below min collapses to min.
   assign lo   = min_ff;
   assign hi   = (max_ff < min_ff) ? min_ff : max_ff;
   assign span = hi - lo;

   // Magnitude of the move; the most negative count saturates.
   assign count_u   = req_ch.move_count;
   assign count_neg = ~count_u + COUNT_BITS'(1);
   assign mag_full  = count_u[COUNT_BITS-1] ? count_neg : count_u;
   assign mag       = mag_full[COUNT_BITS-1] ? '1 : mag_full[MAG_BITS-1:0];

   assign flag_sel   = phase_ff + 2'd1;
   assign next_phase = backward_ff ? (phase_ff - 2'd1) : flag_sel;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      alu_ctrl.down = down_ff;
      unique case (state_ff)
         S_MUL:   alu_ctrl.mode = ALU_MUL;
         S_DIV:   alu_ctrl.mode = ALU_DIV;
         S_FIN:   alu_ctrl.mode = ALU_FIN;
         default: alu_ctrl.mode = ALU_OFF;
      endcase
   end

   stp_alu #(
      .MAG_BITS   (MAG_BITS),
      .DELAY_BITS (DELAY_BITS)
   ) u_stp_alu (
      .ctrl     (alu_ctrl),
      .span_bit (span[cnt_ff]),
      .acc      (acc_ff),
      .mcand    (mcand_ff),
      .ramp     (ramp_ff),
      .base     (down_ff ? hi : lo),
      .acc_next (alu_acc),
      .delay    (alu_delay)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      busy_in       = busy_ff;
      backward_in   = backward_ff;
      total_in      = total_ff;
      index_in      = index_ff;
      ramp_in       = ramp_ff;
      desc_in       = desc_ff;
      phase_in      = phase_ff;
      wait_in       = wait_ff;
      mcand_in      = mcand_ff;
      acc_in        = acc_ff;
      down_in       = down_ff;
      pend_coil_in  = pend_coil_ff;
      pend_flag_in  = pend_flag_ff;
      pend_phase_in = pend_phase_ff;
      pend_delay_in = pend_delay_ff;
      pend_done_in  = pend_done_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_coil_in   = out_coil_ff;
      out_flag_in   = out_flag_ff;
      out_phase_in  = out_phase_ff;
      out_delay_in  = out_delay_ff;
      out_done_in   = out_done_ff;

      // register writes; indexes beyond the list drop
      if (csr_we) begin
         if (csr_index == CSR_MIN_DELAY) begin
            min_in = csr_wdata;
         end else if (csr_index == CSR_MAX_DELAY) begin
            max_in = csr_wdata;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_ch.op == OP_START) begin
                  // a start while busy is dropped
                  if (!busy_ff) begin
                     busy_in     = 1'b1;
                     backward_in = count_u[COUNT_BITS-1];
                     total_in    = mag;
                     index_in    = '0;
                     ramp_in     = mag >> 2;
                     desc_in     = mag - (mag >> 2);
                     phase_in    = req_ch.start_phase;
                     wait_in     = '0;
                  end
               end else if (busy_ff) begin
                  if (wait_ff != '0) begin
                     wait_in = wait_ff - DELAY_BITS'(1);
                  end else if (index_ff < total_ff) begin
                     // take one step, delay worked out below
                     phase_in      = next_phase;
                     index_in      = index_ff + MAG_BITS'(1);
                     pend_coil_in  = coil_of(next_phase);
                     pend_flag_in  = 4'b0001 << flag_sel;
                     pend_phase_in = next_phase;
                     pend_done_in  = 1'b0;
                     acc_in        = '0;
                     cnt_in        = CNT_BITS'(DELAY_BITS - 1);
                     priority if (index_ff < ramp_ff) begin
                        down_in  = 1'b1;
                        mcand_in = index_ff;
                        state_in = S_MUL;
                     end else if (index_ff < desc_ff) begin
                        // flat top: minimum delay, no arithmetic
                        pend_delay_in = lo;
                        wait_in       = (lo == '0) ? '0 : lo - DELAY_BITS'(1);
                        state_in      = S_PUT;
                     end else begin
                        down_in  = 1'b0;
                        mcand_in = index_ff - desc_ff;
                        state_in = S_MUL;
                     end
                  end else begin
                     // move finished: done word
                     busy_in       = 1'b0;
                     pend_coil_in  = '0;
                     pend_flag_in  = '0;
                     pend_phase_in = phase_ff;
                     pend_delay_in = '0;
                     pend_done_in  = 1'b1;
                     state_in      = S_PUT;
                  end
               end
            end
         end
         S_MUL: begin
            acc_in = alu_acc;
            if (cnt_ff == '0) begin
               cnt_in   = CNT_BITS'(DELAY_BITS - 1);
               state_in = S_DIV;
            end else begin
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
         end
         S_DIV: begin
            acc_in = alu_acc;
            if (cnt_ff == '0) begin
               state_in = S_FIN;
            end else begin
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
         end
         S_FIN: begin
            // hi - quotient on the way down, lo + quotient on the way up
            pend_delay_in = alu_delay;
            wait_in       = (alu_delay == '0) ? '0 : alu_delay - DELAY_BITS'(1);
            state_in      = S_PUT;
         end
         S_PUT: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in = 1'b1;
               out_coil_in  = pend_coil_ff;
               out_flag_in  = pend_flag_ff;
               out_phase_in = pend_phase_ff;
               out_delay_in = pend_delay_ff;
               out_done_in  = pend_done_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         min_ff       <= DELAY_BITS'(MIN_DELAY_RESET);
         max_ff       <= DELAY_BITS'(MAX_DELAY_RESET);
         busy_ff      <= 1'b0;
         backward_ff  <= 1'b0;
         total_ff     <= '0;
         index_ff     <= '0;
         ramp_ff      <= '0;
         desc_ff      <= '0;
         phase_ff     <= '0;
         wait_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         busy_ff      <= busy_in;
         backward_ff  <= backward_in;
         total_ff     <= total_in;
         index_ff     <= index_in;
         ramp_ff      <= ramp_in;
         desc_ff      <= desc_in;
         phase_ff     <= phase_in;
         wait_ff      <= wait_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      mcand_ff      <= mcand_in;
      acc_ff        <= acc_in;
      down_ff       <= down_in;
      pend_coil_ff  <= pend_coil_in;
      pend_flag_ff  <= pend_flag_in;
      pend_phase_ff <= pend_phase_in;
      pend_delay_ff <= pend_delay_in;
      pend_done_ff  <= pend_done_in;
      out_coil_ff   <= out_coil_in;
      out_flag_ff   <= out_flag_in;
      out_phase_ff  <= out_phase_in;
      out_delay_ff  <= out_delay_in;
      out_done_ff   <= out_done_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.coil_pattern = out_coil_ff;
   assign rsp_ch.phase_flag   = out_flag_ff;
   assign rsp_ch.phase        = out_phase_ff;
   assign rsp_ch.step_delay   = out_delay_ff;
   assign rsp_ch.move_done    = out_done_ff;

endmodule

`default_nettype wire

[rtl/core/stp_alu.sv]
`default_nettype none

module stp_alu #(
   parameter int MAG_BITS   = 15,
   parameter int DELAY_BITS = 8,
   localparam int PW = MAG_BITS + DELAY_BITS
) (
   input  stp_pkg::alu_ctrl_type  ctrl,
   input  logic                   span_bit,
   input  logic [PW-1:0]          acc,
   input  logic [MAG_BITS-1:0]    mcand,
   input  logic [MAG_BITS-1:0]    ramp,
   input  logic [DELAY_BITS-1:0]  base,
   output logic [PW-1:0]          acc_next,
   output logic [DELAY_BITS-1:0]  delay
);
   import stp_pkg::*;

   localparam int AW = PW + 1;

   logic [AW-1:0]       op_a;
   logic [AW-1:0]       op_b;
   logic                sub;
   logic [AW-1:0]       sum;
   logic                qbit;
   logic [MAG_BITS-1:0] shifted;
   logic [MAG_BITS-1:0] rem_new;

   assign shifted = {acc[PW-2:DELAY_BITS], acc[DELAY_BITS-1]};

   always_comb begin
      op_a = '0;
      op_b = '0;
      sub  = 1'b0;
      unique case (ctrl.mode)
         ALU_MUL: begin
            // shift-add, multiplier bits taken MSB first
            op_a = {1'b0, acc[PW-2:0], 1'b0};
            op_b = span_bit ? AW'(mcand) : '0;
         end
         ALU_DIV: begin
            // restoring step: bring in next dividend bit, trial subtract
            op_a = AW'({acc[PW-1:DELAY_BITS], acc[DELAY_BITS-1]});
            op_b = AW'(ramp);
            sub  = 1'b1;
         end
         ALU_FIN: begin
            op_a = AW'(base);
            op_b = AW'(acc[DELAY_BITS-1:0]);
            sub  = ctrl.down;
         end
         default: begin
            op_a = '0;
         end
      endcase
   end

   assign sum     = op_a + (sub ? ~op_b : op_b) + AW'(sub);
   assign qbit    = ~sum[AW-1];
   assign rem_new = qbit ? sum[MAG_BITS-1:0] : shifted;
   assign delay   = sum[DELAY_BITS-1:0];

   always_comb begin
      if (ctrl.mode == ALU_DIV) begin
         acc_next = {rem_new, acc[DELAY_BITS-2:0], qbit};
      end else begin
         acc_next = sum[PW-1:0];
      end
   end

endmodule

`default_nettype wire

[rtl/core/stp_checker.sv]
`default_nettype none

`include "stepper_trapezoid_profile_assert.svh"

module stp_checker #(
   parameter int DELAY_BITS = 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [7:0]            rsp_coil_pattern,
   input logic [3:0]            rsp_phase_flag,
   input logic [1:0]            rsp_phase,
   input logic [DELAY_BITS-1:0] rsp_step_delay,
   input logic                  rsp_move_done
);
   import stp_pkg::*;

   `STP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_coil_pattern) && $stable(rsp_phase_flag) && $stable(rsp_phase) && $stable(rsp_step_delay) && $stable(rsp_move_done), "stalled word changed")

   `STP_ASSERT_SAME(a_done_empty, clock, reset, rsp_valid && rsp_move_done, rsp_coil_pattern == 8'h00 && rsp_phase_flag == 4'h0 && rsp_step_delay == '0, "done word carries step fields")

   `STP_ASSERT_SAME(a_step_coil, clock, reset, rsp_valid && !rsp_move_done, rsp_coil_pattern == coil_of(rsp_phase), "coil pattern does not match phase")

   `STP_ASSERT_SAME(a_step_flag, clock, reset, rsp_valid && !rsp_move_done, (rsp_phase_flag == (4'b0001 << rsp_phase)) || (rsp_phase_flag == (4'b0001 << (rsp_phase ^ 2'd2))), "phase flag does not match step")

endmodule

bind stepper_trapezoid_profile stp_checker #(
   .DELAY_BITS (DELAY_BITS)
) u_stp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_coil_pattern (rsp_ch.coil_pattern),
   .rsp_phase_flag   (rsp_ch.phase_flag),
   .rsp_phase        (rsp_ch.phase),
   .rsp_step_delay   (rsp_ch.step_delay),
   .rsp_move_done    (rsp_ch.move_done)
);

`default_nettype wire

[sim/stepper_trapezoid_profile_tb.sv]
`timescale 1ns / 100ps

module stepper_trapezoid_profile_tb;

   import stp_pkg::*;

   localparam int COUNT_BITS = 16;
   localparam int DELAY_BITS = 8;

   // Cycles with no handshake on either channel before the run is abandoned.
   // The longest quiet stretch is the deliberate receiver hold below.
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   // Allow the length of a ramp step twice over, plus slack.
   localparam int SETTLE_CYCLES = 4 * DELAY_BITS + 12;

   localparam logic [7:0] COIL_BYTES [4] = '{8'h30, 8'h06, 8'h28, 8'h05};

   typedef struct packed {
      logic [7:0]            coil;
      logic [3:0]            flag;
      logic [1:0]            phase;
      logic [DELAY_BITS-1:0] delay;
      logic                  done;
   } motor_word_type;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        csr_we;
   logic [CSR_INDEX_BITS-1:0]   csr_index;
   logic [DELAY_BITS-1:0]       csr_wdata;

   stp_req_if #(.COUNT_BITS(COUNT_BITS)) req_if();
   stp_rsp_if #(.DELAY_BITS(DELAY_BITS)) rsp_if();

   stepper_trapezoid_profile #(
      .COUNT_BITS(COUNT_BITS),
      .DELAY_BITS(DELAY_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if.sink),
      .rsp_ch    (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // Motion state mirrored on the testbench side, updated per accepted word.
   logic                  mv_busy;
   logic                  mv_backward;
   int unsigned           mv_total;
   int unsigned           mv_index;
   logic [1:0]            mv_phase;
   int unsigned           mv_wait;
   logic [DELAY_BITS-1:0] reg_min;
   logic [DELAY_BITS-1:0] reg_max;

   // Step and done words still owed by the block, oldest first.
   motor_word_type due_words[$];
   motor_word_type oldest;

   int errors;
   int words_checked;
   int moves_started;
   int starts_ignored;
   int step_words;
   int done_words;

   // Idling controls. The receiver percentage and the hold request are
   // written with nonblocking assignments so the receiver picks them up
   // at a well-defined edge.
   int   snd_idle_pct;
   int   rcv_idle_pct;
   logic hold_req;
   logic hold_ack;
   int   hold_left;
   int   quiet_cycles;

   // ---------------------------------------------------------------------
   // Profile arithmetic: ramp down over the first quarter, flat middle,
   // ramp up over the last quarter. Max below min collapses onto min.
   // ---------------------------------------------------------------------
   function automatic logic [DELAY_BITS-1:0] ramp_delay(input int unsigned i);
      int unsigned lo, hi, span, ramp, flat;
      lo   = reg_min;
      hi   = (reg_max < reg_min) ? reg_min : reg_max;
      span = hi - lo;
      ramp = mv_total / 4;
      flat = mv_total - 2 * ramp;
      if (i < ramp)
         return DELAY_BITS'(hi - (i * span) / ramp);
      if (i < ramp + flat || ramp == 0)
         return DELAY_BITS'(lo);
      return DELAY_BITS'(lo + ((i - ramp - flat) * span) / ramp);
   endfunction

   // Advance the mirrored motor by one accepted word and queue any word
   // it owes.
   task automatic advance_motor(input logic op, input logic signed [COUNT_BITS-1:0] count,
                                input logic [1:0] start_phase);
      logic [COUNT_BITS-1:0] mag;
      logic [DELAY_BITS-1:0] d;
      logic [1:0]            ahead;
      logic [1:0]            next;
      motor_word_type        w;
      if (op == OP_START) begin
         // A start in the middle of a move is dropped outright.
         if (mv_busy) begin
            starts_ignored++;
            return;
         end
         mag = count[COUNT_BITS-1] ? (~count + 1'b1) : count;
         // The most negative count saturates to the largest magnitude.
         if (mag[COUNT_BITS-1])
            mag = {1'b0, {(COUNT_BITS-1){1'b1}}};
         mv_busy     = 1'b1;
         mv_backward = count[COUNT_BITS-1];
         mv_total    = mag;
         mv_index    = 0;
         mv_phase    = start_phase;
         mv_wait     = 0;
         moves_started++;
         return;
      end
      // Ticks while idle do nothing.
      if (!mv_busy)
         return;
      if (mv_wait != 0) begin
         mv_wait--;
      end else if (mv_index < mv_total) begin
         d       = ramp_delay(mv_index);
         ahead   = mv_phase + 2'd1;
         next    = mv_backward ? mv_phase - 2'd1 : ahead;
         w.coil  = COIL_BYTES[next];
         // The flag follows the forward neighbor even on a backward step.
         w.flag  = 4'b0001 << ahead;
         w.phase = next;
         w.delay = d;
         w.done  = 1'b0;
         due_words.push_back(w);
         mv_phase = next;
         mv_index++;
         mv_wait  = (d == 0) ? 0 : d - 1;
         step_words++;
      end else begin
         mv_busy = 1'b0;
         w       = '{coil: 8'h00, flag: 4'h0, phase: mv_phase, delay: '0, done: 1'b1};
         due_words.push_back(w);
         done_words++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Mismatch reporting and the result checker
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input int unsigned got, input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("word %0d %s got %0d expected %0d",
                                   words_checked, name, got, want));
   endtask

   // Sample on the edge itself; every driver updates through NBAs, so the
   // values seen here are the ones the handshake completed with.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (due_words.size() == 0) begin
            report_mismatch($sformatf("word %0d arrived with nothing owed", words_checked));
         end else begin
            oldest = due_words.pop_front();
            check_field("coil_pattern", rsp_if.coil_pattern, oldest.coil);
            check_field("phase_flag", rsp_if.phase_flag, oldest.flag);
            check_field("phase", rsp_if.phase, oldest.phase);
            check_field("step_delay", rsp_if.step_delay, oldest.delay);
            check_field("move_done", rsp_if.move_done, oldest.done);
         end
         words_checked++;
      end
   end

   // Receiver: random ready, or a long hold when one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left = 0;
         hold_ack  = hold_req;
      end else begin
         if (hold_ack != hold_req) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // Watchdog: give up when neither channel moves a word for too long.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[%0t] watchdog: no handshake for %0d cycles, %0d words owed",
                  $realtime, STALL_LIMIT, due_words.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic set_idling(input int snd_pct, input int rcv_pct);
      snd_idle_pct = snd_pct;
      rcv_idle_pct <= rcv_pct;
   endtask

   // Offer one word and hold it until accepted. Valid only drops when an
   // idle gap follows, so it never toggles within a step.
   task automatic send_word(input logic op, input logic signed [COUNT_BITS-1:0] count,
                            input logic [1:0] start_phase);
      if ($urandom_range(99) < snd_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < snd_idle_pct);
      end
      req_if.valid       <= 1'b1;
      req_if.op          <= op;
      req_if.move_count  <= count;
      req_if.start_phase <= start_phase;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      advance_motor(op, count, start_phase);
   endtask

   // Ticks carry random don't-care payload so every bit toggles.
   task automatic send_tick();
      send_word(OP_TICK, COUNT_BITS'($urandom), 2'($urandom_range(3)));
   endtask

   // Tick until the mirrored motor reports the move finished.
   task automatic finish_move();
      while (mv_busy)
         send_tick();
   endtask

   task automatic run_move(input logic signed [COUNT_BITS-1:0] count, input logic [1:0] ph);
      send_word(OP_START, count, ph);
      finish_move();
   endtask

   // Drop valid, wait for every owed word, then let the block go quiet.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (due_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both delay registers back to back; only done with the block idle.
   task automatic write_delays(input logic [DELAY_BITS-1:0] min_val,
                               input logic [DELAY_BITS-1:0] max_val);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_MIN_DELAY;
      csr_wdata <= min_val;
      @(posedge clock);
      csr_index <= CSR_MAX_DELAY;
      csr_wdata <= max_val;
      @(posedge clock);
      csr_we <= 1'b0;
      reg_min = min_val;
      reg_max = max_val;
   endtask

   function automatic logic signed [COUNT_BITS-1:0] random_count();
      int unsigned                  pick;
      logic signed [COUNT_BITS-1:0] m;
      pick = $urandom_range(99);
      if (pick < 10)
         m = COUNT_BITS'($urandom_range(3));
      else if (pick < 70)
         m = COUNT_BITS'($urandom_range(16));
      else
         m = COUNT_BITS'($urandom_range(48, 17));
      return $urandom_range(1) ? -m : m;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Default delays: full trapezoid over eight steps.
   task automatic test_reset_profile();
      run_move(8, 0);
   endtask

   // Forward and backward stepping, short moves with no ramp, zero count.
   task automatic test_direction_and_phase();
      write_delays(1, 3);
      run_move(-5, 2);
      run_move(3, 3);
      run_move(0, 1);
      run_move(-1, 0);
      run_move(-4, 1);
   endtask

   // Ticks with no move, and starts that land in the middle of a move.
   task automatic test_idle_and_busy_starts();
      send_tick();
      send_tick();
      send_word(OP_START, 6, 3);
      send_tick();
      send_word(OP_START, 16'sh8000, 2);
      send_tick();
      send_word(OP_START, -3, 0);
      finish_move();
   endtask

   // Min above max, a zero delay, and a wide span with no ramp.
   task automatic test_delay_extremes();
      write_delays(9, 3);
      run_move(8, 2);
      write_delays(0, 4);
      run_move(8, 1);
      write_delays(1, 8'hff);
      run_move(3, 2);
   endtask

   // Hold the receiver off while ticks keep coming; the block must fill
   // and push back on its input without losing a word.
   task automatic test_backpressure();
      set_idling(0, 0);
      write_delays(1, 1);
      hold_req <= ~hold_req;
      run_move(24, 1);
      settle();
      set_idling(15, 48);
   endtask

   // Random moves with random content. Busy-time starts use the full count
   // range and are dropped by the block, so they do not count as items.
   task automatic test_random_mix(input int snd_pct, input int rcv_pct,
                                  input logic [DELAY_BITS-1:0] min_val,
                                  input logic [DELAY_BITS-1:0] max_val,
                                  input int n_items);
      int n;
      write_delays(min_val, max_val);
      set_idling(snd_pct, rcv_pct);
      n = 0;
      while (n < n_items) begin
         if (!mv_busy) begin
            if ($urandom_range(99) < 20) begin
               send_tick();
            end else begin
               send_word(OP_START, random_count(), 2'($urandom_range(3)));
               n++;
            end
         end else if ($urandom_range(99) < 5) begin
            send_word(OP_START, COUNT_BITS'($urandom), 2'($urandom_range(3)));
         end else begin
            send_tick();
            n++;
         end
      end
      finish_move();
      settle();
   endtask

   // Most negative count with min above max at the register ceiling: the
   // first step of a 32767-step backward move at the longest delay, then
   // a few countdown ticks. The move is left running at the end.
   task automatic test_saturated_move();
      set_idling(0, 0);
      write_delays(8'hff, 8'h03);
      send_word(OP_START, 16'sh8000, 3);
      repeat (8) send_tick();
      settle();
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      errors         = 0;
      words_checked  = 0;
      moves_started  = 0;
      starts_ignored = 0;
      step_words     = 0;
      done_words     = 0;
      quiet_cycles   = 0;
      snd_idle_pct   = 15;
      mv_busy        = 1'b0;
      mv_backward    = 1'b0;
      mv_total       = 0;
      mv_index       = 0;
      mv_phase       = 2'd0;
      mv_wait        = 0;
      reg_min        = DELAY_BITS'(MIN_DELAY_RESET);
      reg_max        = DELAY_BITS'(MAX_DELAY_RESET);

      reset              <= 1'b1;
      hold_req           <= 1'b0;
      rcv_idle_pct       <= 48;
      req_if.valid       <= 1'b0;
      req_if.op          <= OP_TICK;
      req_if.move_count  <= '0;
      req_if.start_phase <= 2'd0;
      csr_we             <= 1'b0;
      csr_index          <= CSR_MIN_DELAY;
      csr_wdata          <= '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_profile();
      test_direction_and_phase();
      test_idle_and_busy_starts();
      test_delay_extremes();
      test_backpressure();
      test_random_mix(15, 48, 1, 6, 70);
      test_random_mix(48, 15, 7, 3, 70);
      test_random_mix(0, 0, 2, 12, 70);
      test_saturated_move();

      $display("Covered %0d moves (%0d starts dropped while busy), %0d step and %0d done words.",
               moves_started, starts_ignored, step_words, done_words);
      $display("Idling mixes sender-heavy, receiver-heavy and none; long receiver hold; %s",
               "start of a saturated backward move at the longest delay.");
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/stp_pkg.sv
rtl/core/stp_if.sv
rtl/core/stp_alu.sv
rtl/core/stepper_trapezoid_profile.sv
rtl/core/stp_checker.sv
sim/stepper_trapezoid_profile_tb.sv
